// ===== hdl/sfc_pkg.sv =====
// Shared types, constants and a helper function for the sensor frame checker.
`timescale 1ns / 1ps
package sfc_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CMP_W       = 7;
  localparam int HDR_BYTES   = 7;

  localparam logic [7:0] CRC_POLY_R = 8'hE0;
  localparam logic [4:0] LEN_TH     = 5'd7;

  localparam logic [7:0] HEADER_RST = 8'd159;
  localparam logic [4:0] TH_CODE_RST = 5'd30;
  localparam logic [3:0] NEG_NIB_RST = 4'd0;

  localparam logic [1:0] CFG_HEADER_VALUE  = 2'd0;
  localparam logic [1:0] CFG_THERMO_HYGRO  = 2'd1;
  localparam logic [1:0] CFG_NEG_SIGN_NIB  = 2'd2;

  typedef enum logic [1:0] {
    ST_INCOMPLETE,
    ST_COMPLETE,
    ST_INVALID,
    ST_OVERFLOW
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               frame_valid;
    logic [2:0]         channel_number;
    logic [4:0]         sensor_ident;
    logic [1:0]         message_kind;
    logic [4:0]         sensor_kind;
    logic               thermo_hygro;
    logic signed [7:0]  temperature_whole;
    logic signed [11:0] temperature_tenths;
    logic [7:0]         humidity_percent;
  } out_word_t;

  typedef struct packed {
    logic [7:0] header_value;
    logic [4:0] thermo_hygro_code;
    logic [3:0] negative_sign_nibble;
  } cfg_t;

  typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic [7:0] dat;
    logic [7:0] pxor;
    logic [7:0] pcrc;
  } ent_t;

  typedef struct packed {
    logic    vld;
    status_t status;
    logic    frame_ok;
  } frm_stat_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY_R;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/sfc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module sfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sfc_frame.sv =====
// Frame store: byte count, header bytes, prefix table RAM and check flags.
`timescale 1ns / 1ps
module sfc_frame (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_acc,
  input  sfc_pkg::in_word_t             in_word,
  input  logic                          adv,
  input  logic [7:0]                    header_value,
  output logic                          busy,
  output sfc_pkg::hdr_bytes_t           hdr,
  output sfc_pkg::frm_stat_t            stat
);
  import sfc_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  hdr_bytes_t       hdr_r, hdr_nxt;
  logic [CNT_W-1:0] k0;
  logic [CNT_W-1:0] k0_m1;
  logic             drop0;

  logic             s1_vld_r, s1_vld_nxt;
  logic [7:0]       s1_byte_r;
  logic [CNT_W-1:0] s1_k_r;
  logic             s1_drop_r;

  logic             fwd_hit_r;
  ent_t             fwd_ent_r;

  logic             xor_bad_r, xor_bad_nxt;
  logic             crc_bad_r, crc_bad_nxt;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  ent_t             ram_wdata;
  logic [$bits(ent_t)-1:0] ram_rdata;

  ent_t             prev;
  logic [4:0]       len;
  logic             k_ge2;
  logic             xor_fail, crc_fail, s1_live;
  logic [CMP_W-1:0] k_cmp, len_cmp;

  assign k0    = in_word.frame_start ? '0 : count_r;
  assign drop0 = !in_word.frame_start && (count_r >= CNT_W'(FRAME_BYTES));
  assign k0_m1 = k0 - CNT_W'(1);

  assign ram_re    = in_acc && !drop0 && (k0 != '0);
  assign ram_raddr = k0_m1[IDX_W-1:0];

  always_comb begin
    count_nxt = count_r;
    hdr_nxt   = hdr_r;
    if (in_acc) begin
      if (in_word.frame_start) begin
        hdr_nxt = '0;
      end
      if (!drop0) begin
        count_nxt = k0 + CNT_W'(1);
        for (int i = 0; i < HDR_BYTES; i++) begin
          if (k0 == CNT_W'(i)) begin
            hdr_nxt[i] = in_word.data_byte;
          end
        end
      end
    end
  end

  assign s1_vld_nxt = in_acc ? 1'b1 : (adv ? 1'b0 : s1_vld_r);

  assign prev    = fwd_hit_r ? fwd_ent_r : ent_t'(ram_rdata);
  assign len     = hdr_r[2][5:1];
  assign k_ge2   = s1_k_r >= CNT_W'(2);
  assign s1_live = s1_vld_r && !s1_drop_r;
  assign k_cmp   = CMP_W'(s1_k_r);
  assign len_cmp = CMP_W'(len);

  always_comb begin
    ram_wdata.dat  = s1_byte_r;
    ram_wdata.pxor = '0;
    ram_wdata.pcrc = '0;
    if (s1_k_r != '0) begin
      ram_wdata.pxor = prev.pxor ^ s1_byte_r;
      ram_wdata.pcrc = crc_byte(prev.pcrc, s1_byte_r);
    end
  end

  assign ram_we    = s1_live && adv;
  assign ram_waddr = s1_k_r[IDX_W-1:0];

  assign xor_fail = s1_live && k_ge2 &&
                    (((k_cmp == len_cmp + CMP_W'(1)) && (prev.pxor != s1_byte_r)) ||
                     ((k_cmp == CMP_W'(2)) && (len == '0) && (prev.dat != '0)));
  assign crc_fail = s1_live && k_ge2 &&
                    (k_cmp == len_cmp + CMP_W'(2)) && (prev.pcrc != s1_byte_r);

  always_comb begin
    xor_bad_nxt = xor_bad_r;
    crc_bad_nxt = crc_bad_r;
    if (s1_live && (s1_k_r == '0)) begin
      xor_bad_nxt = 1'b0;
      crc_bad_nxt = 1'b0;
    end
    xor_bad_nxt = xor_bad_nxt | xor_fail;
    crc_bad_nxt = crc_bad_nxt | crc_fail;
  end

  always_comb begin
    logic hdr_ok;
    logic len_hit;
    hdr_ok  = hdr_r[0] == header_value;
    len_hit = CMP_W'(count_r) == len_cmp + CMP_W'(3);
    stat.vld      = s1_vld_r;
    stat.frame_ok = len_hit && hdr_ok && !xor_bad_nxt && !crc_bad_nxt;
    if (s1_drop_r) begin
      stat.status = ST_OVERFLOW;
    end else if (!hdr_ok || xor_bad_nxt || crc_bad_nxt) begin
      stat.status = ST_INVALID;
    end else if (len_hit) begin
      stat.status = ST_COMPLETE;
    end else begin
      stat.status = ST_INCOMPLETE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      hdr_r     <= '0;
      s1_vld_r  <= 1'b0;
      xor_bad_r <= 1'b0;
      crc_bad_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      hdr_r    <= hdr_nxt;
      s1_vld_r <= s1_vld_nxt;
      if (adv) begin
        xor_bad_r <= xor_bad_nxt;
        crc_bad_r <= crc_bad_nxt;
      end
      if (in_acc) begin
        fwd_hit_r <= ram_we && ram_re && (ram_waddr == ram_raddr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_word.data_byte;
      s1_k_r    <= k0;
      s1_drop_r <= drop0;
      fwd_ent_r <= ram_wdata;
    end
  end

  sfc_ram #(
    .WIDTH($bits(ent_t)),
    .DEPTH(FRAME_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy = s1_vld_r;
  assign hdr  = hdr_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FRAME_BYTES))
    else $error("byte count beyond frame size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_acc && !in_word.frame_start && !drop0 |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("byte count did not advance on stored word");

  a_fwd_entry: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && fwd_hit_r |-> s1_k_r != '0)
    else $error("forwarded entry for first frame byte");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_drop_r |-> count_r == CNT_W'(FRAME_BYTES))
    else $error("word dropped while buffer not full");

endmodule

// ===== hdl/sfc_decode.sv =====
// Field decode of the stored header bytes and assembly of the result word.
`timescale 1ns / 1ps
module sfc_decode (
  input  sfc_pkg::hdr_bytes_t hdr,
  input  sfc_pkg::cfg_t       cfg,
  input  sfc_pkg::frm_stat_t  stat,
  output sfc_pkg::out_word_t  word
);
  import sfc_pkg::*;

  logic [4:0]  len;
  logic        th;
  logic        neg;
  logic [2:0]  chan;
  logic [7:0]  whole_mag;
  logic [10:0] tenths_mag;
  logic [7:0]  hum;
  logic [3:0]  b4_hi, b4_lo, b5_lo, b6_hi, b6_lo;

  assign len   = hdr[2][5:1];
  assign b4_hi = hdr[4][7:4];
  assign b4_lo = hdr[4][3:0];
  assign b5_lo = hdr[5][3:0];
  assign b6_hi = hdr[6][7:4];
  assign b6_lo = hdr[6][3:0];
  assign th    = (hdr[3][4:0] == cfg.thermo_hygro_code) && (len == LEN_TH);
  assign neg   = hdr[5][7:4] == cfg.negative_sign_nibble;

  always_comb begin
    case (hdr[1][7:5])
      3'd1:    chan = 3'd1;
      3'd2:    chan = 3'd2;
      3'd3:    chan = 3'd3;
      3'd4:    chan = 3'd6;
      3'd5:    chan = 3'd4;
      3'd6:    chan = 3'd5;
      default: chan = 3'd0;
    endcase
  end

  always_comb begin
    whole_mag  = '0;
    tenths_mag = '0;
    hum        = '0;
    if (th) begin
      whole_mag  = 8'(b5_lo * 8'd10) + 8'(b4_hi);
      tenths_mag = 11'(b5_lo * 11'd100) + 11'(b4_hi * 11'd10) + 11'(b4_lo);
      hum        = 8'(b6_hi * 8'd10) + 8'(b6_lo);
    end
  end

  always_comb begin
    word.status             = stat.status;
    word.frame_valid        = stat.frame_ok && (chan != '0);
    word.channel_number     = chan;
    word.sensor_ident       = hdr[1][4:0];
    word.message_kind       = hdr[3][7:6];
    word.sensor_kind        = hdr[3][4:0];
    word.thermo_hygro       = th;
    word.temperature_whole  = neg ? -whole_mag : whole_mag;
    word.temperature_tenths = neg ? -12'(tenths_mag) : 12'(tenths_mag);
    word.humidity_percent   = hum;
  end

endmodule

// ===== hdl/sensor_frame_checker_core.sv =====
// Top level of the sensor frame checker: handshake, configuration and result register.
//
// Input channel (in_valid, in_stall, in_word): one frame byte per word, with a
// frame start flag that restarts the frame before the byte is stored.
// Result channel (out_valid, out_stall, out_word): one result word for every
// input word: status, validity flag and the decoded sensor fields.
// Configuration port (cfg_we, cfg_index, cfg_wdata): header value, thermo hygro
// type code and negative sign nibble; write only while no word is in flight.
// Order: an accepted word is held in the stage-two registers, and its result is
// loaded into the output register when stage two advances, and leaves from there.
// Throughput: one word per cycle while in_stall is low; the prefix table RAM
// is written by stage two and read by stage one, with a bypass register for
// an entry written in the same cycle.
// Reset: the frame is empty, the control and configuration registers take
// their reset values and no result is pending. The RAM is not cleared; only
// entries of the current frame are ever read.
// Stall: when out_stall holds a pending result and stage two is also full,
// in_stall rises and the block takes no new word until the result leaves.
`timescale 1ns / 1ps
module sensor_frame_checker_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sfc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output sfc_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import sfc_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r;
  out_word_t  dec_word;
  hdr_bytes_t hdr;
  frm_stat_t  stat;
  logic       busy;
  logic       in_acc;
  logic       adv;

  assign adv      = busy && (!out_valid_r || !out_stall);
  assign in_stall = busy && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_VALUE: cfg_nxt.header_value         = cfg_wdata;
        CFG_THERMO_HYGRO: cfg_nxt.thermo_hygro_code    = cfg_wdata[4:0];
        CFG_NEG_SIGN_NIB: cfg_nxt.negative_sign_nibble = cfg_wdata[3:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value         <= HEADER_RST;
      cfg_r.thermo_hygro_code    <= TH_CODE_RST;
      cfg_r.negative_sign_nibble <= NEG_NIB_RST;
      out_valid_r                <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= dec_word;
    end
  end

  sfc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .in_word     (in_word),
    .adv         (adv),
    .header_value(cfg_r.header_value),
    .busy        (busy),
    .hdr         (hdr),
    .stat        (stat)
  );

  sfc_decode u_decode (
    .hdr (hdr),
    .cfg (cfg_r),
    .stat(stat),
    .word(dec_word)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && busy)
    else $error("input stalled without a held result");

  a_adv_loads: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && adv |=> out_valid_r)
    else $error("result lost on advance");

  a_stat_match: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> stat.vld)
    else $error("stage status out of step with pipeline");

endmodule
